@@ design/b32d_pkg.sv @@
// Shared types and constants for the Base32 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package b32d_pkg;

	localparam int unsigned SymW      = 8;
	localparam int unsigned ValW      = 5;
	localparam int unsigned LeftW     = 7;
	localparam int unsigned CntW      = 3;
	localparam int unsigned StatusW   = 2;
	localparam int unsigned CmdDepth  = 2;
	localparam int unsigned ResDepth  = 2;

	localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
	localparam logic [StatusW-1:0] STATUS_BAD_CHAR = 2'd1;
	localparam logic [StatusW-1:0] STATUS_PAD      = 2'd2;

	// One classified character between front and back.
	typedef struct packed {
		logic [ValW-1:0] val;
		logic            bad;
		logic            last;
	} cmd_t;

	// One finished result.
	typedef struct packed {
		logic               byte_valid;
		logic [7:0]         out_byte;
		logic               string_done;
		logic [StatusW-1:0] status;
	} res_t;

endpackage
`default_nettype wire

@@ design/b32d_front.sv @@
// Front end: maps one ASCII character onto its Base32 value or flags it invalid.
`timescale 1ns / 1ps
`default_nettype none
module b32d_front (
	input  wire logic [b32d_pkg::SymW-1:0] symbol,
	input  wire logic                      end_of_string,
	output b32d_pkg::cmd_t                 cmd
);

	logic [b32d_pkg::SymW-1:0] diff;

	always_comb begin
		diff     = '0;
		cmd.val  = '0;
		cmd.bad  = 1'b0;
		cmd.last = end_of_string;
		case (symbol) inside
			[8'h41:8'h5A]: begin
				diff    = symbol - 8'h41;
				cmd.val = diff[b32d_pkg::ValW-1:0];
			end
			[8'h32:8'h37]: begin
				diff    = symbol - 8'h32 + 8'd26;
				cmd.val = diff[b32d_pkg::ValW-1:0];
			end
			default: begin
				cmd.bad = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/b32d_cmd_fifo.sv @@
// Short queue of classified characters between front and back.
`timescale 1ns / 1ps
`default_nettype none
module b32d_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire b32d_pkg::cmd_t wr_data,
	output logic                full,
	output logic                rd_valid,
	input  wire logic           rd_en,
	output b32d_pkg::cmd_t      rd_data
);

	b32d_pkg::cmd_t mem_q [b32d_pkg::CmdDepth];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full     = (cnt_q == 2'(b32d_pkg::CmdDepth));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/b32d_back.sv @@
// Back end: bit buffer, byte assembly, status and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module b32d_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire b32d_pkg::cmd_t cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  wire logic           pop,
	output b32d_pkg::res_t      res
);

	logic [b32d_pkg::LeftW-1:0] left_q;
	logic [b32d_pkg::CntW-1:0]  cnt_q;
	logic                       bad_q;

	b32d_pkg::res_t res_q [b32d_pkg::ResDepth];
	logic           res_wr_ptr_q;
	logic           res_rd_ptr_q;
	logic [1:0]     res_cnt_q;

	logic                       bad_n;
	logic [11:0]                acc;
	logic [3:0]                 bits;
	logic [2:0]                 sh;
	logic [b32d_pkg::CntW-1:0]  cnt_n;
	logic [b32d_pkg::LeftW-1:0] left_n;
	logic [7:0]                 mask;
	b32d_pkg::res_t             res_wdata;
	logic                       res_pop;

	assign res_pop = pop && !empty;
	assign empty   = (res_cnt_q == 2'd0);
	assign res     = res_q[res_rd_ptr_q];
	// Take a character whenever the result queue has room, counting a slot freed this cycle.
	assign cmd_pop = cmd_valid &&
		((res_cnt_q != 2'(b32d_pkg::ResDepth)) || res_pop);

	always_comb begin
		bad_n  = bad_q | cmd.bad;
		acc    = {left_q, cmd.val};
		bits   = {1'b0, cnt_q} + 4'd5;
		sh     = '0;
		cnt_n  = cnt_q;
		left_n = left_q;
		mask   = '0;
		res_wdata.byte_valid  = 1'b0;
		res_wdata.out_byte    = '0;
		res_wdata.string_done = cmd.last;
		res_wdata.status      = b32d_pkg::STATUS_OK;
		if (!bad_n) begin
			if (bits >= 4'd8) begin
				sh = 3'(bits - 4'd8);
				res_wdata.byte_valid = 1'b1;
				res_wdata.out_byte   = 8'(acc >> sh);
				cnt_n = sh;
			end else begin
				cnt_n = bits[2:0];
			end
			mask   = (8'd1 << cnt_n) - 8'd1;
			left_n = acc[b32d_pkg::LeftW-1:0] & mask[b32d_pkg::LeftW-1:0];
		end
		if (bad_n) begin
			res_wdata.status = b32d_pkg::STATUS_BAD_CHAR;
		end else if (cmd.last && cnt_n != '0 && left_n != '0) begin
			res_wdata.status = b32d_pkg::STATUS_PAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			cnt_q  <= '0;
			bad_q  <= 1'b0;
		end else if (cmd_pop) begin
			// Clear the string state once its last character is done.
			if (cmd.last) begin
				left_q <= '0;
				cnt_q  <= '0;
				bad_q  <= 1'b0;
			end else begin
				left_q <= left_n;
				cnt_q  <= cnt_n;
				bad_q  <= bad_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_q[res_wr_ptr_q] <= res_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_ptr_q <= 1'b0;
			res_rd_ptr_q <= 1'b0;
			res_cnt_q    <= 2'd0;
		end else begin
			if (cmd_pop) begin
				res_wr_ptr_q <= ~res_wr_ptr_q;
			end
			if (res_pop) begin
				res_rd_ptr_q <= ~res_rd_ptr_q;
			end
			case ({cmd_pop, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_res_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= 2'(b32d_pkg::ResDepth))
		else $error("result queue overfilled");

	a_pad_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && res_wdata.status == b32d_pkg::STATUS_PAD) |-> cmd.last)
		else $error("padding status before end of string");

	a_bad_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && res_wdata.status == b32d_pkg::STATUS_BAD_CHAR) |-> !res_wdata.byte_valid)
		else $error("byte given after invalid character");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.last) |=> (cnt_q == '0 && left_q == '0 && !bad_q))
		else $error("state not cleared after end of string");
`endif

endmodule
`default_nettype wire

@@ design/base32_stream_decoder_core.sv @@
// Top level of the unpadded Base32 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
// Decodes unpadded Base32 (A-Z, 2-7), one character per request, into bytes, most
// significant bits first. Every character gives exactly one result: byte_valid marks
// a finished byte, string_done copies end_of_string, and status reads 1 once an
// invalid character has been seen in the string (no more bytes until it ends) or 2
// when the last character leaves nonzero padding bits. A new character is taken every
// cycle while results keep draining; each character passes through the character queue
// and then the result queue on its way to the result ports. Both queues hold two
// entries, so the input side keeps flowing while a result waits.
module base32_stream_decoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] symbol,
	input  wire logic       end_of_string,
	input  wire logic       push,
	output logic            full,
	output logic            empty,
	input  wire logic       pop,
	output logic            byte_valid,
	output logic [7:0]      out_byte,
	output logic            string_done,
	output logic [1:0]      status
);

	b32d_pkg::cmd_t front_cmd;
	b32d_pkg::cmd_t queue_cmd;
	b32d_pkg::res_t res;
	logic           cmd_valid;
	logic           cmd_pop;

	b32d_front u_front (
		.symbol        (symbol),
		.end_of_string (end_of_string),
		.cmd           (front_cmd)
	);

	b32d_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (front_cmd),
		.full     (full),
		.rd_valid (cmd_valid),
		.rd_en    (cmd_pop),
		.rd_data  (queue_cmd)
	);

	b32d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (queue_cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign byte_valid  = res.byte_valid;
	assign out_byte    = res.out_byte;
	assign string_done = res.string_done;
	assign status      = res.status;

endmodule
`default_nettype wire
